### rtl/core/ebrf_pkg.sv
// shared types and constants for the eight-bit register-file cpu step block
// no dependencies
`default_nettype none
package ebrf_pkg;

   localparam int MemAddrBitsDef = 16;

   // high opcode nibble groups
   localparam logic [3:0] GRP_LDN  = 4'h0;
   localparam logic [3:0] GRP_INC  = 4'h1;
   localparam logic [3:0] GRP_DEC  = 4'h2;
   localparam logic [3:0] GRP_SBR  = 4'h3;
   localparam logic [3:0] GRP_LDA  = 4'h4;
   localparam logic [3:0] GRP_STR  = 4'h5;
   localparam logic [3:0] GRP_IO   = 4'h6;
   localparam logic [3:0] GRP_MISC = 4'h7;
   localparam logic [3:0] GRP_GLO  = 4'h8;
   localparam logic [3:0] GRP_GHI  = 4'h9;
   localparam logic [3:0] GRP_PLO  = 4'hA;
   localparam logic [3:0] GRP_PHI  = 4'hB;
   localparam logic [3:0] GRP_LBR  = 4'hC;
   localparam logic [3:0] GRP_SEP  = 4'hD;
   localparam logic [3:0] GRP_SEX  = 4'hE;
   localparam logic [3:0] GRP_ALU  = 4'hF;

   // low nibble codes in the misc group
   localparam logic [3:0] MISC_RET  = 4'h0;
   localparam logic [3:0] MISC_DIS  = 4'h1;
   localparam logic [3:0] MISC_LDXA = 4'h2;
   localparam logic [3:0] MISC_STXD = 4'h3;
   localparam logic [3:0] MISC_ADC  = 4'h4;
   localparam logic [3:0] MISC_SDB  = 4'h5;
   localparam logic [3:0] MISC_SHRC = 4'h6;
   localparam logic [3:0] MISC_SMB  = 4'h7;
   localparam logic [3:0] MISC_SAV  = 4'h8;
   localparam logic [3:0] MISC_MARK = 4'h9;
   localparam logic [3:0] MISC_REQ  = 4'hA;
   localparam logic [3:0] MISC_SEQ  = 4'hB;
   localparam logic [3:0] MISC_ADCI = 4'hC;
   localparam logic [3:0] MISC_SDBI = 4'hD;
   localparam logic [3:0] MISC_SHLC = 4'hE;
   localparam logic [3:0] MISC_SMBI = 4'hF;

   // special low nibbles
   localparam logic [3:0] IO_IRX     = 4'h0;
   localparam logic [3:0] IO_ILLEGAL = 4'h8;
   localparam logic [3:0] ALU_SHR    = 4'h6;
   localparam logic [3:0] ALU_SHL    = 4'hE;
   localparam logic [3:0] LDN_IDL    = 4'h0;
   localparam logic [3:0] MARK_REG   = 4'h2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_FETCH,
      ST_DECODE,
      ST_EXEC,
      ST_LONG2,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic take_req;
      logic load_wr;
      logic fetch;
      logic decode;
      logic exec;
      logic long2;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_load;
      logic long_taken;
   } stat_type;

endpackage
`default_nettype wire

### rtl/core/ebrf_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module ebrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     wr_en,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/core/ebrf_ctrl.sv
// sequencer for fetch, decode, execute and result handoff
// depends on ebrf_pkg
`default_nettype none
module ebrf_ctrl
   import ebrf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (stat.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = stat.is_load ? ST_LOAD : ST_FETCH;
         ST_LOAD:   state_in = ST_FINISH;
         ST_FETCH:  state_in = ST_DECODE;
         ST_DECODE: state_in = ST_EXEC;
         ST_EXEC:   state_in = stat.long_taken ? ST_LONG2 : ST_FINISH;
         ST_LONG2:  state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.take_req = req_tvalid;
         end
         ST_LOAD:   cmd.load_wr = 1'b1;
         ST_FETCH:  cmd.fetch = 1'b1;
         ST_DECODE: cmd.decode = 1'b1;
         ST_EXEC:   cmd.exec = 1'b1;
         ST_LONG2:  cmd.long2 = 1'b1;
         ST_FINISH: cmd.finish = out_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/core/ebrf_dp.sv
// datapath: register file, accumulator, flags, byte memory and result registers
// depends on ebrf_pkg and ebrf_ram
`default_nettype none
module ebrf_dp
   import ebrf_pkg::*;
#(
   parameter int MEM_ADDR_BITS = MemAddrBitsDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic        action,
   input  wire logic [15:0] load_address,
   input  wire logic [7:0]  load_data,
   input  wire logic [3:0]  ext_flags,
   input  wire logic [7:0]  port_in_data,
   output logic             out_strobe,
   output logic [2:0]       out_port,
   output logic [7:0]       out_data,
   output logic             q_level,
   output logic [7:0]       acc_value,
   output logic [15:0]      pc_value,
   output logic             idle_hit,
   output logic             illegal_op,
   output logic [7:0]       last_opcode
);

   localparam int MemDepth = 1 << MEM_ADDR_BITS;

   logic [15:0] rf_ff [16];
   logic [7:0]  d_ff, d_in;
   logic        df_ff, df_in;
   logic [3:0]  p_ff, p_in, x_ff, x_in;
   logic        q_ff, q_in, ie_ff, ie_in;
   logic [7:0]  t_ff, t_in;
   logic [7:0]  op_ff;
   logic [15:0] a_ff;
   logic [3:0]  ridx_ff;
   logic [7:0]  hi_ff;
   logic [MEM_ADDR_BITS-1:0] clr_ff;

   logic [15:0] ld_addr_ff;
   logic [7:0]  ld_data_ff, bus_ff;
   logic [3:0]  ef_ff;

   logic        strobe_ff, strobe_in, idle_ff, idle_in, ill_ff, ill_in;
   logic [2:0]  port_ff, port_in;
   logic [7:0]  odata_ff, odata_in;

   logic        out_strobe_ff, out_q_ff, out_idle_ff, out_ill_ff;
   logic [2:0]  out_port_ff;
   logic [7:0]  out_data_ff, out_acc_ff, out_op_ff;
   logic [15:0] out_pc_ff;

   logic [3:0]  rd_idx, dec_idx, wr_idx;
   logic [15:0] rd_val, wr_val;
   logic        rf_we;

   logic [15:0] mem_addr16;
   logic        mem_we;
   logic [7:0]  mem_wdata, rdata;

   logic        ex_rf_we, ex_mem_we, ex_long;
   logic [15:0] ex_rf_val;
   logic [7:0]  ex_wdata;
   logic        alu_en;
   logic [7:0]  alu_a, alu_b;
   logic        alu_c;
   logic [8:0]  alu_sum;
   logic        cond, take;
   logic [3:0]  n, hi, dn;

   function automatic logic ext_flags_sel(input logic [3:0] ef, input logic [1:0] sel);
      ext_flags_sel = ef[sel];
   endfunction

   // register chosen as the memory pointer for an opcode
   always_comb begin
      hi  = rdata[7:4];
      dn  = rdata[3:0];
      dec_idx = dn;
      unique case (hi)
         GRP_SBR, GRP_LBR: dec_idx = p_ff;
         GRP_IO:           dec_idx = x_ff;
         GRP_MISC: begin
            if (dn == MISC_MARK) begin
               dec_idx = MARK_REG;
            end else if (dn == MISC_ADCI || dn == MISC_SDBI || dn == MISC_SMBI) begin
               dec_idx = p_ff;
            end else begin
               dec_idx = x_ff;
            end
         end
         GRP_ALU:          dec_idx = (dn[3] && dn != ALU_SHL) ? p_ff : x_ff;
         default:          dec_idx = dn;
      endcase
   end

   assign rd_idx = cmd.decode ? dec_idx : p_ff;
   assign rd_val = rf_ff[rd_idx];

   // execute stage
   assign n = op_ff[3:0];

   always_comb begin
      d_in      = d_ff;
      df_in     = df_ff;
      p_in      = p_ff;
      x_in      = x_ff;
      q_in      = q_ff;
      ie_in     = ie_ff;
      t_in      = t_ff;
      strobe_in = 1'b0;
      port_in   = '0;
      odata_in  = '0;
      idle_in   = 1'b0;
      ill_in    = 1'b0;
      ex_rf_we  = 1'b0;
      ex_rf_val = a_ff;
      ex_mem_we = 1'b0;
      ex_wdata  = d_ff;
      ex_long   = 1'b0;
      alu_en    = 1'b0;
      alu_a     = d_ff;
      alu_b     = rdata;
      alu_c     = df_ff;
      cond      = 1'b0;
      take      = 1'b0;
      unique case (op_ff[7:4])
         GRP_LDN: begin
            if (n == LDN_IDL) idle_in = 1'b1;
            else d_in = rdata;
         end
         GRP_INC: begin
            ex_rf_we  = 1'b1;
            ex_rf_val = a_ff + 16'd1;
         end
         GRP_DEC: begin
            ex_rf_we  = 1'b1;
            ex_rf_val = a_ff - 16'd1;
         end
         GRP_SBR: begin
            unique case (n[2:0])
               3'd0:    cond = 1'b1;
               3'd1:    cond = q_ff;
               3'd2:    cond = (d_ff == 8'd0);
               3'd3:    cond = df_ff;
               default: cond = ext_flags_sel(ef_ff, n[1:0]);
            endcase
            take      = n[3] ? !cond : cond;
            ex_rf_we  = 1'b1;
            ex_rf_val = take ? {a_ff[15:8], rdata} : a_ff + 16'd1;
         end
         GRP_LDA: begin
            d_in      = rdata;
            ex_rf_we  = 1'b1;
            ex_rf_val = a_ff + 16'd1;
         end
         GRP_STR: begin
            ex_mem_we = 1'b1;
            ex_wdata  = d_ff;
         end
         GRP_IO: begin
            if (n == IO_IRX) begin
               ex_rf_we  = 1'b1;
               ex_rf_val = a_ff + 16'd1;
            end else if (!n[3]) begin
               strobe_in = 1'b1;
               port_in   = n[2:0];
               odata_in  = rdata;
               ex_rf_we  = 1'b1;
               ex_rf_val = a_ff + 16'd1;
            end else if (n == IO_ILLEGAL) begin
               ill_in = 1'b1;
            end else begin
               port_in   = n[2:0];
               ex_mem_we = 1'b1;
               ex_wdata  = bus_ff;
               d_in      = bus_ff;
            end
         end
         GRP_MISC: begin
            unique case (n)
               MISC_RET, MISC_DIS: begin
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff + 16'd1;
                  x_in      = rdata[7:4];
                  p_in      = rdata[3:0];
                  ie_in     = (n == MISC_RET);
               end
               MISC_LDXA: begin
                  d_in      = rdata;
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff + 16'd1;
               end
               MISC_STXD: begin
                  ex_mem_we = 1'b1;
                  ex_wdata  = d_ff;
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff - 16'd1;
               end
               MISC_ADC: alu_en = 1'b1;
               MISC_SDB: begin
                  alu_en = 1'b1;
                  alu_a  = rdata;
                  alu_b  = ~d_ff;
               end
               MISC_SHRC: begin
                  df_in = d_ff[0];
                  d_in  = {df_ff, d_ff[7:1]};
               end
               MISC_SMB: begin
                  alu_en = 1'b1;
                  alu_b  = ~rdata;
               end
               MISC_SAV: begin
                  ex_mem_we = 1'b1;
                  ex_wdata  = t_ff;
               end
               MISC_MARK: begin
                  t_in      = {x_ff, p_ff};
                  ex_mem_we = 1'b1;
                  ex_wdata  = {x_ff, p_ff};
                  x_in      = p_ff;
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff - 16'd1;
               end
               MISC_REQ: q_in = 1'b0;
               MISC_SEQ: q_in = 1'b1;
               MISC_ADCI: begin
                  alu_en    = 1'b1;
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff + 16'd1;
               end
               MISC_SDBI: begin
                  alu_en    = 1'b1;
                  alu_a     = rdata;
                  alu_b     = ~d_ff;
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff + 16'd1;
               end
               MISC_SHLC: begin
                  df_in = d_ff[7];
                  d_in  = {d_ff[6:0], df_ff};
               end
               MISC_SMBI: begin
                  alu_en    = 1'b1;
                  alu_b     = ~rdata;
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff + 16'd1;
               end
               default: d_in = d_ff;
            endcase
         end
         GRP_GLO: d_in = a_ff[7:0];
         GRP_GHI: d_in = a_ff[15:8];
         GRP_PLO: begin
            ex_rf_we  = 1'b1;
            ex_rf_val = {a_ff[15:8], d_ff};
         end
         GRP_PHI: begin
            ex_rf_we  = 1'b1;
            ex_rf_val = {d_ff, a_ff[7:0]};
         end
         GRP_LBR: begin
            unique case (n[1:0])
               2'd0:    cond = 1'b1;
               2'd1:    cond = q_ff;
               2'd2:    cond = (d_ff == 8'd0);
               default: cond = df_ff;
            endcase
            unique case (n)
               4'h0, 4'h1, 4'h2, 4'h3: begin
                  ex_long   = cond;
                  ex_rf_we  = !cond;
                  ex_rf_val = a_ff + 16'd2;
               end
               4'h9, 4'hA, 4'hB: begin
                  ex_long   = !cond;
                  ex_rf_we  = cond;
                  ex_rf_val = a_ff + 16'd2;
               end
               4'h4: ex_rf_we = 1'b0;
               4'h5, 4'h6, 4'h7: begin
                  ex_rf_we  = !cond;
                  ex_rf_val = a_ff + 16'd2;
               end
               4'h8: begin
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff + 16'd2;
               end
               4'hC: begin
                  ex_rf_we  = ie_ff;
                  ex_rf_val = a_ff + 16'd2;
               end
               default: begin
                  ex_rf_we  = cond;
                  ex_rf_val = a_ff + 16'd2;
               end
            endcase
         end
         GRP_SEP: p_in = n;
         GRP_SEX: x_in = n;
         default: begin
            if (n == ALU_SHR) begin
               df_in = d_ff[0];
               d_in  = {1'b0, d_ff[7:1]};
            end else if (n == ALU_SHL) begin
               df_in = d_ff[7];
               d_in  = {d_ff[6:0], 1'b0};
            end else begin
               if (n[3]) begin
                  ex_rf_we  = 1'b1;
                  ex_rf_val = a_ff + 16'd1;
               end
               unique case (n[2:0])
                  3'd0: d_in = rdata;
                  3'd1: d_in = d_ff | rdata;
                  3'd2: d_in = d_ff & rdata;
                  3'd3: d_in = d_ff ^ rdata;
                  3'd4: begin
                     alu_en = 1'b1;
                     alu_c  = 1'b0;
                  end
                  3'd5: begin
                     alu_en = 1'b1;
                     alu_a  = rdata;
                     alu_b  = ~d_ff;
                     alu_c  = 1'b1;
                  end
                  default: begin
                     alu_en = 1'b1;
                     alu_b  = ~rdata;
                     alu_c  = 1'b1;
                  end
               endcase
            end
         end
      endcase
      alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {8'd0, alu_c};
      if (alu_en) begin
         d_in  = alu_sum[7:0];
         df_in = alu_sum[8];
      end
   end

   assign stat.long_taken = cmd.exec && ex_long;
   assign stat.is_load    = action;
   assign stat.clear_last = &clr_ff;

   // register file write port
   always_comb begin
      rf_we  = 1'b0;
      wr_idx = p_ff;
      wr_val = rd_val + 16'd1;
      if (cmd.fetch) begin
         rf_we = 1'b1;
      end else if (cmd.exec) begin
         rf_we  = ex_rf_we;
         wr_idx = ridx_ff;
         wr_val = ex_rf_val;
      end else if (cmd.long2) begin
         rf_we  = 1'b1;
         wr_val = {hi_ff, rdata};
      end
   end

   // memory port
   always_comb begin
      mem_addr16 = rd_val;
      mem_we     = 1'b0;
      mem_wdata  = ex_wdata;
      if (cmd.clear_wr) begin
         mem_addr16 = 16'(clr_ff);
         mem_we     = 1'b1;
         mem_wdata  = 8'd0;
      end else if (cmd.load_wr) begin
         mem_addr16 = ld_addr_ff;
         mem_we     = 1'b1;
         mem_wdata  = ld_data_ff;
      end else if (cmd.exec) begin
         mem_addr16 = ex_mem_we ? a_ff : a_ff + 16'd1;
         mem_we     = ex_mem_we;
      end
   end

   ebrf_ram #(
      .WIDTH (8),
      .DEPTH (MemDepth)
   ) u_mem (
      .clock   (clock),
      .addr    (mem_addr16[MEM_ADDR_BITS-1:0]),
      .wr_en   (mem_we),
      .wr_data (mem_wdata),
      .rd_data (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            rf_ff[i] <= '0;
         end
         d_ff   <= '0;
         df_ff  <= 1'b0;
         p_ff   <= '0;
         x_ff   <= '0;
         q_ff   <= 1'b0;
         ie_ff  <= 1'b1;
         t_ff   <= '0;
         clr_ff <= '0;
      end else begin
         if (rf_we) begin
            rf_ff[wr_idx] <= wr_val;
         end
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.exec) begin
            d_ff  <= d_in;
            df_ff <= df_in;
            p_ff  <= p_in;
            x_ff  <= x_in;
            q_ff  <= q_in;
            ie_ff <= ie_in;
            t_ff  <= t_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         ld_addr_ff <= load_address;
         ld_data_ff <= load_data;
         ef_ff      <= ext_flags;
         bus_ff     <= port_in_data;
         op_ff      <= '0;
         strobe_ff  <= 1'b0;
         port_ff    <= '0;
         odata_ff   <= '0;
         idle_ff    <= 1'b0;
         ill_ff     <= 1'b0;
      end
      if (cmd.decode) begin
         op_ff   <= rdata;
         a_ff    <= rd_val;
         ridx_ff <= dec_idx;
      end
      if (cmd.exec) begin
         hi_ff     <= rdata;
         strobe_ff <= strobe_in;
         port_ff   <= port_in;
         odata_ff  <= odata_in;
         idle_ff   <= idle_in;
         ill_ff    <= ill_in;
      end
      if (cmd.finish) begin
         out_strobe_ff <= strobe_ff;
         out_port_ff   <= port_ff;
         out_data_ff   <= odata_ff;
         out_q_ff      <= q_ff;
         out_acc_ff    <= d_ff;
         out_pc_ff     <= rd_val;
         out_idle_ff   <= idle_ff;
         out_ill_ff    <= ill_ff;
         out_op_ff     <= op_ff;
      end
   end

   assign out_strobe  = out_strobe_ff;
   assign out_port    = out_port_ff;
   assign out_data    = out_data_ff;
   assign q_level     = out_q_ff;
   assign acc_value   = out_acc_ff;
   assign pc_value    = out_pc_ff;
   assign idle_hit    = out_idle_ff;
   assign illegal_op  = out_ill_ff;
   assign last_opcode = out_op_ff;

endmodule
`default_nettype wire

### rtl/core/eight_bit_register_file_cpu_step.sv
// top level: one load or one instruction step per word, result word per item
// depends on ebrf_pkg, ebrf_ctrl and ebrf_dp
// states: a load word runs idle, load, finish; a step word runs idle, fetch, decode, exec,
// finish, with long2 before finish on a taken long branch; a new word is taken only in idle
// reset: synchronous; afterwards a clearing pass zeroes memory before the first word is taken
`default_nettype none
module eight_bit_register_file_cpu_step
   import ebrf_pkg::*;
#(
   parameter int MEM_ADDR_BITS = MemAddrBitsDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // load_address, load_data, ext_flags, port_in_data
   input  wire logic        req_tuser,  // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata   // out_strobe, out_port, out_data, q_level,
                                        // acc_value, pc_value, idle_hit, illegal_op,
                                        // last_opcode
);

   cmd_type  cmd;
   stat_type stat;

   logic        out_strobe, q_level, idle_hit, illegal_op;
   logic [2:0]  out_port;
   logic [7:0]  out_data, acc_value, last_opcode;
   logic [15:0] pc_value;

   ebrf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ebrf_dp #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .action       (req_tuser),
      .load_address (req_tdata[15:0]),
      .load_data    (req_tdata[23:16]),
      .ext_flags    (req_tdata[27:24]),
      .port_in_data (req_tdata[35:28]),
      .out_strobe   (out_strobe),
      .out_port     (out_port),
      .out_data     (out_data),
      .q_level      (q_level),
      .acc_value    (acc_value),
      .pc_value     (pc_value),
      .idle_hit     (idle_hit),
      .illegal_op   (illegal_op),
      .last_opcode  (last_opcode)
   );

   assign rsp_tdata = {1'b0, last_opcode, illegal_op, idle_hit, pc_value, acc_value,
                       q_level, out_data, out_port, out_strobe};

endmodule
`default_nettype wire

### rtl/core/ebrf_chk.sv
// port-level checks for the cpu step block, bound to the top level
// depends on eight_bit_register_file_cpu_step
`default_nettype none
module ebrf_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // idle flag only with the idle opcode
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37] |-> rsp_tdata[46:39] == 8'h00)
      else $error("idle flag with wrong opcode");

   // illegal flag only with the undefined opcode and no output
   a_illegal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38] |-> rsp_tdata[46:39] == 8'h68 && !rsp_tdata[0])
      else $error("illegal flag mismatch");

   // output strobe only from an output opcode with its port
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[46:43] == 4'h6 && rsp_tdata[3:1] == rsp_tdata[41:39]
         && rsp_tdata[3:1] != 3'd0)
      else $error("output strobe mismatch");

endmodule

bind eight_bit_register_file_cpu_step ebrf_chk u_ebrf_chk (.*);
`default_nettype wire
